### rtl/sortable_bounded_stack_top_assert.svh
// assertion macros for the sortable stack checker
`ifndef SORTABLE_BOUNDED_STACK_TOP_ASSERT_SVH
`define SORTABLE_BOUNDED_STACK_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sbs_pkg.sv
// shared types and constants for the sortable stack
package sbs_pkg;

  localparam int WORD_W      = 32;
  localparam int CMD_W       = 2;
  localparam int COUNT_W     = 5;
  localparam int CAP_W       = 5;
  localparam int STATUS_W    = 2;
  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SORT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // operation applied to every cell in the same cycle
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_SORT,
    OP_ROTATE
  } op_t;

  // per-cell control, built from the shared op, the sort phase and the fill level
  typedef struct packed {
    op_t  op;
    logic held;    // cell holds a live entry
    logic bottom;  // cell holds the oldest live entry
    logic upper;   // in this sort phase the cell pairs with the one below
    logic paired;  // its sort partner is live as well
  } cell_ctrl_t;

endpackage

### rtl/sbs_cell.sv
// one stack entry: shifts, compare-exchanges and rotates with its neighbors
module sbs_cell (
  input  logic                              clk,
  input  sbs_pkg::cell_ctrl_t               ctl,
  input  logic signed [sbs_pkg::WORD_W-1:0] prev_word,
  input  logic signed [sbs_pkg::WORD_W-1:0] next_word,
  input  logic signed [sbs_pkg::WORD_W-1:0] wrap_word,
  output logic signed [sbs_pkg::WORD_W-1:0] word
);
  import sbs_pkg::*;

  // entry update, index 0 is the top of the stack
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_PUSH: begin
        word <= prev_word;
      end
      OP_POP: begin
        word <= next_word;
      end
      OP_SORT: begin
        // upper keeps the larger, lower keeps the smaller
        if (ctl.paired) begin
          if (ctl.upper) begin
            if (next_word > word) word <= next_word;
          end else begin
            if (word > prev_word) word <= prev_word;
          end
        end
      end
      OP_ROTATE: begin
        if (ctl.bottom) begin
          word <= wrap_word;
        end else if (ctl.held) begin
          word <= next_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/sbs_ctrl.sv
// command sequencer, fill level, capacity register and result register
module sbs_ctrl #(
  parameter int  DEPTH  = sbs_pkg::DEPTH_DEF,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sbs_pkg::CMD_W-1:0]           cmd,
  input  logic signed [sbs_pkg::WORD_W-1:0]   push_value,
  input  logic signed [sbs_pkg::WORD_W-1:0]   top_word,
  input  logic signed [sbs_pkg::WORD_W-1:0]   second_word,
  input  logic                                cfg_write,
  input  logic [sbs_pkg::CAP_W-1:0]           cfg_data,
  output sbs_pkg::op_t                        op,
  output logic                                phase_odd,
  output logic [FILL_W-1:0]                   fill,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sbs_pkg::WORD_W-1:0]   value,
  output logic [sbs_pkg::COUNT_W-1:0]         count,
  output logic [sbs_pkg::STATUS_W-1:0]        status,
  output logic                                last
);
  import sbs_pkg::*;

  localparam int CW = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]          state, state_next;
  logic [FILL_W-1:0]   fill_next;
  logic [FILL_W-1:0]   step, step_next;
  logic [CAP_W-1:0]    capacity;

  logic                       slot_free, accept, full, empty;
  logic [CW-1:0]              fill_ext, step_ext, dump_n;
  logic                       emit_now, dump_last;
  logic                       load;
  logic signed [WORD_W-1:0]   ld_value;
  logic [FILL_W-1:0]          ld_fill;
  logic [STATUS_W-1:0]        ld_status;
  logic                       ld_last;

  // handshake and level flags
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign empty     = (fill == '0);
  assign fill_ext  = CW'(fill);
  assign step_ext  = CW'(step);
  assign full      = (fill_ext >= CW'(capacity)) || (fill == FILL_W'(DEPTH));
  assign dump_n    = (fill_ext > CW'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : fill_ext;
  assign emit_now  = step_ext < CW'(MAX_RESULTS);
  assign dump_last = (CW'(step_ext + CW'(1)) == dump_n);
  assign phase_odd = step[0];

  // sequencer
  always_comb begin
    state_next = state;
    fill_next  = fill;
    step_next  = step;
    op         = OP_HOLD;
    load       = 1'b0;
    ld_value   = '0;
    ld_fill    = fill;
    ld_status  = ST_OK;
    ld_last    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_PUSH: begin
              load = 1'b1;
              if (full) begin
                ld_value  = empty ? '0 : top_word;
                ld_status = ST_OVERFLOW;
              end else begin
                op        = OP_PUSH;
                fill_next = fill + FILL_W'(1);
                ld_fill   = fill_next;
                ld_value  = push_value;
              end
            end
            CMD_POP: begin
              load = 1'b1;
              if (empty) begin
                ld_status = ST_EMPTY;
              end else begin
                op        = OP_POP;
                fill_next = fill - FILL_W'(1);
                ld_fill   = fill_next;
                ld_value  = (fill > FILL_W'(1)) ? second_word : '0;
              end
            end
            CMD_SORT: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                step_next  = '0;
                state_next = S_SORT;
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                step_next  = '0;
                state_next = S_DUMP;
              end
            end
          endcase
        end
      end
      S_SORT: begin
        // one odd-even transposition phase per cycle, fill phases in all
        if (step != fill) begin
          op        = OP_SORT;
          step_next = step + FILL_W'(1);
        end else if (slot_free) begin
          load       = 1'b1;
          ld_value   = top_word;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        // rotate the live entries once around, emitting the top in the first MAX_RESULTS steps
        if (!emit_now || slot_free) begin
          op = OP_ROTATE;
          if (emit_now) begin
            load     = 1'b1;
            ld_value = top_word;
            ld_last  = dump_last;
          end
          if (step == fill - FILL_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            step_next = step + FILL_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      step      <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      step  <= step_next;
      if (cfg_write) capacity <= cfg_data;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      value  <= ld_value;
      count  <= COUNT_W'(ld_fill);
      status <= ld_status;
      last   <= ld_last;
    end
  end

endmodule

### rtl/sortable_bounded_stack_top.sv
// top level of the sortable stack: sequencer plus a row of entry cells
//
// Input channel in_valid/in_ready carries one command item (cmd, push_value);
// output channel out_valid/out_ready carries result items (value, count,
// status, last). Capacity is written through cfg_write/cfg_data; the user must
// write it only while idle; the block does not enforce this. Push and pop: the
// result is registered in the cycle after the item is accepted. Sort: the live
// entries run one odd-even transposition phase per cycle, fill phases in all.
// Dump: the live entries rotate once around the cell row, one step per cycle;
// the first (at most 16) steps each emit one result, last marks the final.
// A new item is taken only when the sequencer is idle and the result
// register is empty or being read in that cycle, so push and pop stream at
// one item per cycle while out_ready stays high.
// A stalled receiver holds the result register; sort finishes its phases and
// then waits, dump waits step by step before each emitted entry.
// Reset empties the stack, sets capacity to 16 and drops out_valid; entry
// contents are not cleared.
module sortable_bounded_stack_top #(
  parameter int DEPTH = sbs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sbs_pkg::CMD_W-1:0]         cmd,
  input  logic signed [sbs_pkg::WORD_W-1:0] push_value,
  input  logic                              cfg_write,
  input  logic [sbs_pkg::CAP_W-1:0]         cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sbs_pkg::WORD_W-1:0] value,
  output logic [sbs_pkg::COUNT_W-1:0]       count,
  output logic [sbs_pkg::STATUS_W-1:0]      status,
  output logic                              last
);
  import sbs_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  op_t                      op;
  logic                     phase_odd;
  logic [FILL_W-1:0]        fill;
  logic signed [WORD_W-1:0] words [DEPTH];
  cell_ctrl_t               ctl [DEPTH];

  // sequencer
  sbs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .push_value  (push_value),
    .top_word    (words[0]),
    .second_word (words[1]),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .op          (op),
    .phase_odd   (phase_odd),
    .fill        (fill),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value),
    .count       (count),
    .status      (status),
    .last        (last)
  );

  // row of cells, index 0 at the top
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic held, upper;

    assign held  = FILL_W'(i) < fill;
    assign upper = ((i % 2) == 1) ? phase_odd : !phase_odd;

    assign ctl[i].op     = op;
    assign ctl[i].held   = held;
    assign ctl[i].bottom = (FILL_W'(i + 1) == fill);
    assign ctl[i].upper  = upper;
    assign ctl[i].paired = upper ? (FILL_W'(i + 1) < fill)
                                 : ((i != 0) ? held : 1'b0);

    sbs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .prev_word ((i == 0) ? push_value : words[(i == 0) ? 0 : i - 1]),
      .next_word (words[(i == DEPTH - 1) ? i : i + 1]),
      .wrap_word (words[0]),
      .word      (words[i])
    );
  end

endmodule

### rtl/sbs_checker.sv
// port-level checker for the sortable stack, bound to the top level
`include "sortable_bounded_stack_top_assert.svh"

module sbs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sbs_pkg::WORD_W-1:0] value,
  input logic [sbs_pkg::COUNT_W-1:0]       count,
  input logic [sbs_pkg::STATUS_W-1:0]      status,
  input logic                              last
);
  import sbs_pkg::*;

  // a new item never enters while a result sits stalled
  `SBS_ASSERT_NOW(a_no_accept_on_stall, in_valid && in_ready, !out_valid || out_ready, "item accepted while result stalled")

  // an empty report is a single zero result
  `SBS_ASSERT_NOW(a_empty_result, out_valid && (status == ST_EMPTY), (value == '0) && (count == '0) && last, "malformed empty result")

  // only dump gives non-final results, and those are always ok
  `SBS_ASSERT_NOW(a_mid_run_ok, out_valid && !last, status == ST_OK, "non-final result with error status")

  // a stalled result holds
  `SBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(count) && $stable(status) && $stable(last), "stalled result changed")

endmodule

bind sortable_bounded_stack_top sbs_checker u_sbs_checker (.*);
